### hdl/rrb_pkg.sv
// Shared constants, types and tables for the rangefinder ray builder.
// Depends on nothing; every other file of the block imports it.
package rrb_pkg;

  localparam int QUAT_FRAC_BITS = 14;
  localparam int RANGE_BITS     = 18;
  localparam int DIR_BITS       = (60 - RANGE_BITS) / 2;

  localparam int Q_W      = 16;
  localparam int PROD_W   = 2 * Q_W + 2;
  localparam int MSB_W    = 6;
  localparam int SQ_W     = 2 * DIR_BITS;
  localparam int DEN_W    = SQ_W + 2;
  localparam int NS_W     = SQ_W + 4;
  localparam int NMAG_W   = DEN_W + 1;
  localparam int NLO_W    = 23;
  localparam int NHI_W    = NMAG_W - NLO_W;
  localparam int NUM_W    = 64;
  localparam int DDEN_W   = 45;
  localparam int DQ_W     = 22;
  localparam int TR_W     = DDEN_W + DQ_W;
  localparam int CONE_W   = 21;
  localparam int WEIGHT_W = 17;

  localparam int CORDIC_STEPS = 30;
  localparam int CX_W         = 33;
  localparam int CY_W         = 31;
  localparam logic [15:0] FOV_CAP = 16'd46323;
  localparam logic [CONE_W-1:0] CONE_MAX = {CONE_W{1'b1}};

  localparam logic signed [Q_W-1:0] QUAT_ONE = Q_W'(1 << QUAT_FRAC_BITS);

  // Pipeline bookkeeping: index of the stage register that holds an item.
  localparam int NST         = 54;
  localparam int ST_QUAT_IN  = 23;
  localparam int ST_CONE_IN  = 30;

  localparam int IN_TDATA_W  = 240;
  localparam int OUT_TDATA_W = 272;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_RANGE = 3'd0,
    CFG_MAX_RANGE = 3'd1,
    CFG_MOUNT_W   = 3'd2,
    CFG_MOUNT_X   = 3'd3,
    CFG_MOUNT_Y   = 3'd4,
    CFG_MOUNT_Z   = 3'd5,
    CFG_BEAM_FOV  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0] range;
    logic                  hit;
    logic signed [Q_W-1:0] att_w;
    logic signed [Q_W-1:0] att_x;
    logic signed [Q_W-1:0] att_y;
    logic signed [Q_W-1:0] att_z;
    logic signed [31:0]    org_e;
    logic signed [31:0]    org_n;
    logic signed [31:0]    org_u;
    logic [7:0]            cov;
    logic [6:0]            qual;
    logic [7:0]            tag;
    logic [31:0]           ts;
  } meta_t;

  localparam logic [30:0] ATAN_Q30 [CORDIC_STEPS] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
    31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
    31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
    31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
    31'd127, 31'd63, 31'd31, 31'd15, 31'd7, 31'd3, 31'd1
  };

endpackage

### hdl/rangefinder_ray_builder_core.sv
// Top level of the rangefinder ray builder: channels, configuration and stage bookkeeping.
// Depends on rrb_pkg, rrb_quat, rrb_cordic and rrb_div.
//
//  channel  | ports                     | contents
//  ---------+---------------------------+------------------------------------------
//  reading  | in_tvalid/tready/tdata    | range, attitude, origin, quality, tags
//  ray      | out_tvalid/tready/tdata   | origin, endpoint, weight, cone, tags
//           | out_tuser                 | hit flag
//  config   | cfg_we/index/wdata        | seven registers, write only
//
// One reading per clock is taken while the output register is empty or being taken.
// The pipeline is the stage registers ahead of the dividers (the last eight of them compose and
// normalize the quaternions), the 22-stage dividers and the output register.
// Readings below the minimum range are taken but give no ray.
// When the output register is full and not taken, every stage holds.
// Reset clears all stage valid bits and loads register defaults.
module rangefinder_ray_builder_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // range_mm, att_w, att_x, att_y, att_z, origin_east, origin_north, origin_up,
  // covariance, quality, vehicle_tag, timestamp; zero padded
  input  logic [rrb_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // ray_origin_east, ray_origin_north, ray_origin_up, endpoint_east,
  // endpoint_north, endpoint_up, weight, cone_radius, out_vehicle_tag,
  // out_timestamp; zero padded
  output logic [rrb_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // hit
  output logic                              out_tuser,
  input  logic                              cfg_we,
  input  logic [rrb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import rrb_pkg::*;

  logic [RANGE_BITS-1:0] min_r, max_r;
  logic signed [Q_W-1:0] mnt_w_r, mnt_x_r, mnt_y_r, mnt_z_r;
  logic [15:0]           fov_r;

  logic                  en;
  logic [NST-1:0]        v_r;
  meta_t                 meta_r [NST];
  meta_t                 meta_nxt;
  logic                  keep;
  logic [RANGE_BITS-1:0] rng;

  logic [2:0][NUM_W-1:0] qn_num;
  logic [DDEN_W-1:0]     qn_den;
  logic [2:0]            qn_neg;
  logic signed [CX_W-1:0] cx, cy;

  logic [RANGE_BITS+CY_W-1:0] cone_prod;
  logic [NUM_W-1:0]      cone_num_r, cone_num_nxt;
  logic [DDEN_W-1:0]     cone_den_r, cone_den_nxt;
  logic [1:0]            cone_flg_r, cone_flg_nxt;
  logic [NUM_W-1:0]      w_num_r;
  logic [DDEN_W-1:0]     w_den_r;
  logic [8:0]            cov9;

  logic [DQ_W-1:0]       ned_q [3];
  logic [1:0]            ned_aux [3];
  logic [DQ_W-1:0]       cone_q, w_q;
  logic [1:0]            cone_aux, w_aux;

  logic signed [31:0]    ned_s [3];
  logic [CONE_W-1:0]     cone_val;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                  out_tuser_r, out_valid_r;
  meta_t                 mo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= '0;
      max_r   <= '0;
      mnt_w_r <= QUAT_ONE;
      mnt_x_r <= '0;
      mnt_y_r <= '0;
      mnt_z_r <= '0;
      fov_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_RANGE: min_r   <= cfg_wdata[RANGE_BITS-1:0];
        CFG_MAX_RANGE: max_r   <= cfg_wdata[RANGE_BITS-1:0];
        CFG_MOUNT_W:   mnt_w_r <= $signed(cfg_wdata[Q_W-1:0]);
        CFG_MOUNT_X:   mnt_x_r <= $signed(cfg_wdata[Q_W-1:0]);
        CFG_MOUNT_Y:   mnt_y_r <= $signed(cfg_wdata[Q_W-1:0]);
        CFG_MOUNT_Z:   mnt_z_r <= $signed(cfg_wdata[Q_W-1:0]);
        CFG_BEAM_FOV:  fov_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  assign rng  = in_tdata[RANGE_BITS-1:0];
  assign keep = !(rng < min_r) && !(max_r == '0 && rng == '0);

  always_comb begin
    meta_nxt.hit   = !(max_r != '0 && rng >= max_r);
    meta_nxt.range = meta_nxt.hit ? rng : max_r;
    meta_nxt.att_w = $signed(in_tdata[33:18]);
    meta_nxt.att_x = $signed(in_tdata[49:34]);
    meta_nxt.att_y = $signed(in_tdata[65:50]);
    meta_nxt.att_z = $signed(in_tdata[81:66]);
    meta_nxt.org_e = $signed(in_tdata[113:82]);
    meta_nxt.org_n = $signed(in_tdata[145:114]);
    meta_nxt.org_u = $signed(in_tdata[177:146]);
    meta_nxt.cov   = (in_tdata[185:178] == 8'd255) ? 8'd0 : in_tdata[185:178];
    meta_nxt.qual  = (in_tdata[193:186] == 8'd0 || in_tdata[193:186] > 8'd100) ?
                     7'd100 : in_tdata[192:186];
    meta_nxt.tag   = in_tdata[201:194];
    meta_nxt.ts    = in_tdata[233:202];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[NST-2:0], in_tvalid && keep};
      out_valid_r <= v_r[NST-1];
    end
  end

  rrb_quat u_quat (
    .clk     (clk),
    .en      (en),
    .att_w   (meta_r[ST_QUAT_IN].att_w),
    .att_x   (meta_r[ST_QUAT_IN].att_x),
    .att_y   (meta_r[ST_QUAT_IN].att_y),
    .att_z   (meta_r[ST_QUAT_IN].att_z),
    .mnt_w   (mnt_w_r),
    .mnt_x   (mnt_x_r),
    .mnt_y   (mnt_y_r),
    .mnt_z   (mnt_z_r),
    .range_i (meta_r[ST_QUAT_IN].range),
    .num_o   (qn_num),
    .den_o   (qn_den),
    .neg_o   (qn_neg)
  );

  rrb_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .fov_i (fov_r),
    .x_o   (cx),
    .y_o   (cy)
  );

  always_comb begin
    cone_prod = meta_r[ST_CONE_IN].range * cy[CY_W-1:0];
    cone_flg_nxt[0] = (fov_r == '0) || cy[CX_W-1] || (cy == '0);
    cone_flg_nxt[1] = !cone_flg_nxt[0] && (cx[CX_W-1] || (cx == '0));
    if (cone_flg_nxt != 2'b00) begin
      cone_num_nxt = '0;
      cone_den_nxt = DDEN_W'(1);
    end else begin
      cone_num_nxt = NUM_W'(cone_prod) + NUM_W'(cx[CY_W-1:1]);
      cone_den_nxt = DDEN_W'(cx[CY_W-1:0]);
    end
  end

  assign cov9 = 9'd9 + 9'(meta_r[ST_CONE_IN].cov);

  always_ff @(posedge clk) begin
    if (en) begin
      meta_r[0] <= meta_nxt;
      for (int k = 1; k < NST; k++) meta_r[k] <= meta_r[k-1];
      cone_num_r <= cone_num_nxt;
      cone_den_r <= cone_den_nxt;
      cone_flg_r <= cone_flg_nxt;
      w_num_r    <= NUM_W'(28'd1179648 * 28'(meta_r[ST_CONE_IN].qual))
                  + NUM_W'(16'(cov9) * 16'd100);
      w_den_r    <= DDEN_W'(16'(cov9) * 16'd200);
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= mo.hit;
    end
  end

  genvar g;
  for (g = 0; g < 3; g++) begin : g_ned
    rrb_div u_div (
      .clk    (clk),
      .en     (en),
      .num_i  (qn_num[g]),
      .den_i  (qn_den),
      .aux_i  ({1'b0, qn_neg[g]}),
      .quot_o (ned_q[g]),
      .aux_o  (ned_aux[g])
    );
  end

  rrb_div u_div_cone (
    .clk    (clk),
    .en     (en),
    .num_i  (cone_num_r),
    .den_i  (cone_den_r),
    .aux_i  (cone_flg_r),
    .quot_o (cone_q),
    .aux_o  (cone_aux)
  );

  rrb_div u_div_weight (
    .clk    (clk),
    .en     (en),
    .num_i  (w_num_r),
    .den_i  (w_den_r),
    .aux_i  (2'b00),
    .quot_o (w_q),
    .aux_o  (w_aux)
  );

  assign mo = meta_r[NST-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ned_s[i] = ned_aux[i][0] ? -$signed(32'(ned_q[i])) : $signed(32'(ned_q[i]));
    end
    if (cone_aux[0]) begin
      cone_val = '0;
    end else if (cone_aux[1] || w_aux[1] || cone_q > DQ_W'(CONE_MAX)) begin
      cone_val = CONE_MAX;
    end else begin
      cone_val = cone_q[CONE_W-1:0];
    end
    out_tdata_nxt = {2'b00, mo.ts, mo.tag, cone_val, w_q[WEIGHT_W-1:0],
                     mo.org_u - ned_s[2], mo.org_n + ned_s[0], mo.org_e + ned_s[1],
                     mo.org_u, mo.org_n, mo.org_e};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(v_r))
    else $error("stage valid bits moved during a stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("ray presented right after reset");

  a_weight_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[208:192] <= 17'd65536)
    else $error("weight above one");

  a_ned_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] |-> ned_q[0] <= DQ_W'(mo.range))
    else $error("rotated offset exceeds range");

endmodule

### hdl/rrb_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rrb_pkg.
module rrb_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rrb_pkg::NUM_W-1:0]  num_i,
  input  logic [rrb_pkg::DDEN_W-1:0] den_i,
  input  logic [1:0]                aux_i,
  output logic [rrb_pkg::DQ_W-1:0]   quot_o,
  output logic [1:0]                aux_o
);
  import rrb_pkg::*;

  logic [NUM_W-1:0]  rem_r [DQ_W-1];
  logic [DDEN_W-1:0] dv_r  [DQ_W-1];
  logic [DQ_W-1:0]   q_r   [DQ_W];
  logic [1:0]        aux_r [DQ_W];

  genvar k;
  for (k = 0; k < DQ_W; k++) begin : g_st
    logic [NUM_W-1:0]  rem_s;
    logic [DDEN_W-1:0] den_s;
    logic [DQ_W-1:0]   q_s;
    logic [1:0]        aux_s;
    logic [TR_W-1:0]   trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_s = num_i;
      assign den_s = den_i;
      assign q_s   = '0;
      assign aux_s = aux_i;
    end else begin : g_next
      assign rem_s = rem_r[k-1];
      assign den_s = dv_r[k-1];
      assign q_s   = q_r[k-1];
      assign aux_s = aux_r[k-1];
    end

    assign trial = TR_W'(den_s) << (DQ_W - 1 - k);
    assign ge    = TR_W'(rem_s) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]   <= q_s | (ge ? (DQ_W'(1) << (DQ_W - 1 - k)) : '0);
        aux_r[k] <= aux_s;
      end
    end

    if (k < DQ_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? (rem_s - trial[NUM_W-1:0]) : rem_s;
          dv_r[k]  <= den_s;
        end
      end
    end
  end

  assign quot_o = q_r[DQ_W-1];
  assign aux_o  = aux_r[DQ_W-1];

endmodule

### hdl/rrb_cordic.sv
// Pipelined rotation-mode CORDIC giving the sine and cosine of half the beam angle.
// Depends on rrb_pkg.
module rrb_cordic (
  input  logic                            clk,
  input  logic                            en,
  input  logic [15:0]                     fov_i,
  output logic signed [rrb_pkg::CX_W-1:0] x_o,
  output logic signed [rrb_pkg::CX_W-1:0] y_o
);
  import rrb_pkg::*;

  logic signed [CX_W-1:0] x_r [CORDIC_STEPS];
  logic signed [CX_W-1:0] y_r [CORDIC_STEPS];
  logic signed [CX_W-1:0] z_r [CORDIC_STEPS-1];
  logic [15:0]            fov_c;

  assign fov_c = (fov_i > FOV_CAP) ? FOV_CAP : fov_i;

  genvar k;
  for (k = 0; k < CORDIC_STEPS; k++) begin : g_st
    logic signed [CX_W-1:0] xs, ys, zs, at;

    if (k == 0) begin : g_first
      assign xs = CX_W'(1) <<< 30;
      assign ys = '0;
      assign zs = $signed(CX_W'({fov_c, 15'd0}));
    end else begin : g_next
      assign xs = x_r[k-1];
      assign ys = y_r[k-1];
      assign zs = z_r[k-1];
    end

    assign at = $signed(CX_W'(ATAN_Q30[k]));

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[CX_W-1]) begin
          x_r[k] <= xs - (ys >>> k);
          y_r[k] <= ys + (xs >>> k);
        end else begin
          x_r[k] <= xs + (ys >>> k);
          y_r[k] <= ys - (xs >>> k);
        end
      end
    end

    if (k < CORDIC_STEPS - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en) begin
          z_r[k] <= zs[CX_W-1] ? (zs + at) : (zs - at);
        end
      end
    end
  end

  assign x_o = x_r[CORDIC_STEPS-1];
  assign y_o = y_r[CORDIC_STEPS-1];

endmodule

### hdl/rrb_quat.sv
// Quaternion composition, block normalization and rotation numerators, eight stages.
// Depends on rrb_pkg.
module rrb_quat (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [rrb_pkg::Q_W-1:0]       att_w,
  input  logic signed [rrb_pkg::Q_W-1:0]       att_x,
  input  logic signed [rrb_pkg::Q_W-1:0]       att_y,
  input  logic signed [rrb_pkg::Q_W-1:0]       att_z,
  input  logic signed [rrb_pkg::Q_W-1:0]       mnt_w,
  input  logic signed [rrb_pkg::Q_W-1:0]       mnt_x,
  input  logic signed [rrb_pkg::Q_W-1:0]       mnt_y,
  input  logic signed [rrb_pkg::Q_W-1:0]       mnt_z,
  input  logic [rrb_pkg::RANGE_BITS-1:0]       range_i,
  output logic [2:0][rrb_pkg::NUM_W-1:0]       num_o,
  output logic [rrb_pkg::DDEN_W-1:0]           den_o,
  output logic [2:0]                           neg_o
);
  import rrb_pkg::*;

  logic signed [Q_W-1:0]    qa [4];
  logic signed [Q_W-1:0]    qb [4];
  logic signed [2*Q_W-1:0]  pr_r [4][4];
  logic signed [PROD_W-1:0] p_r [4];
  logic [PROD_W-1:0]        m_r [4];
  logic [3:0]               sg_r, sg4_r;
  logic [MSB_W-1:0]         msb_r;
  logic [DIR_BITS-1:0]      u_r [4];
  logic [SQ_W-1:0]          sq_r [4];
  logic [SQ_W-1:0]          cr_r [4];
  logic [3:0]               cs_r;
  logic [DEN_W-1:0]         den6_r, den7_r;
  logic [NMAG_W-1:0]        nm_r [3];
  logic [2:0]               ng6_r, ng7_r, ng8_r;
  logic [RANGE_BITS+NLO_W-1:0] plo_r [3];
  logic [RANGE_BITS+NHI_W-1:0] phi_r [3];
  logic [NUM_W-1:0]         num_r [3];
  logic [DDEN_W-1:0]        den8_r;
  logic [RANGE_BITS-1:0]    rg1_r, rg2_r, rg3_r, rg4_r, rg5_r, rg6_r;

  logic signed [PROD_W-1:0] ps [4];
  logic [PROD_W-1:0]        ms [4];
  logic [PROD_W-1:0]        orv;
  logic [MSB_W-1:0]         msb_s;
  logic [PROD_W-1:0]        sv [4];
  logic signed [NS_W-1:0]   e_sq [4];
  logic signed [NS_W-1:0]   e_cr [4];
  logic signed [NS_W-1:0]   nv [3];
  logic signed [NS_W-1:0]   na [3];

  always_comb begin
    if (att_w == '0 && att_x == '0 && att_y == '0 && att_z == '0) begin
      qa[0] = QUAT_ONE; qa[1] = '0; qa[2] = '0; qa[3] = '0;
    end else begin
      qa[0] = att_w; qa[1] = att_x; qa[2] = att_y; qa[3] = att_z;
    end
    if (mnt_w == '0 && mnt_x == '0 && mnt_y == '0 && mnt_z == '0) begin
      qb[0] = QUAT_ONE; qb[1] = '0; qb[2] = '0; qb[3] = '0;
    end else begin
      qb[0] = mnt_w; qb[1] = mnt_x; qb[2] = mnt_y; qb[3] = mnt_z;
    end
  end

  always_comb begin
    ps[0] = PROD_W'(pr_r[0][0]) - PROD_W'(pr_r[1][1]) - PROD_W'(pr_r[2][2])
          - PROD_W'(pr_r[3][3]);
    ps[1] = PROD_W'(pr_r[0][1]) + PROD_W'(pr_r[1][0]) + PROD_W'(pr_r[2][3])
          - PROD_W'(pr_r[3][2]);
    ps[2] = PROD_W'(pr_r[0][2]) - PROD_W'(pr_r[1][3]) + PROD_W'(pr_r[2][0])
          + PROD_W'(pr_r[3][1]);
    ps[3] = PROD_W'(pr_r[0][3]) + PROD_W'(pr_r[1][2]) - PROD_W'(pr_r[2][1])
          + PROD_W'(pr_r[3][0]);
  end

  // The leading one of the OR of all magnitudes is the leading one of the largest.
  always_comb begin
    orv = '0;
    for (int i = 0; i < 4; i++) begin
      ms[i] = p_r[i][PROD_W-1] ? PROD_W'(-p_r[i]) : PROD_W'(p_r[i]);
      orv   = orv | ms[i];
    end
    msb_s = '0;
    for (int b = 0; b < PROD_W; b++) begin
      if (orv[b]) msb_s = MSB_W'(b);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (msb_r >= MSB_W'(DIR_BITS - 1)) begin
        sv[i] = m_r[i] >> (msb_r - MSB_W'(DIR_BITS - 1));
      end else begin
        sv[i] = m_r[i] << (MSB_W'(DIR_BITS - 1) - msb_r);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      e_sq[i] = $signed(NS_W'(sq_r[i]));
      e_cr[i] = cs_r[i] ? -$signed(NS_W'(cr_r[i])) : $signed(NS_W'(cr_r[i]));
    end
    nv[0] = e_sq[0] + e_sq[1] - e_sq[2] - e_sq[3];
    nv[1] = (e_cr[0] + e_cr[1]) <<< 1;
    nv[2] = (e_cr[2] - e_cr[3]) <<< 1;
    for (int i = 0; i < 3; i++) begin
      na[i] = nv[i][NS_W-1] ? -nv[i] : nv[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pr_r[i][j] <= qa[i] * qb[j];
        end
      end
      rg1_r <= range_i;

      for (int i = 0; i < 4; i++) p_r[i] <= ps[i];
      rg2_r <= rg1_r;

      for (int i = 0; i < 4; i++) begin
        m_r[i]  <= ms[i];
        sg_r[i] <= p_r[i][PROD_W-1];
      end
      msb_r <= msb_s;
      rg3_r <= rg2_r;

      for (int i = 0; i < 4; i++) u_r[i] <= sv[i][DIR_BITS-1:0];
      sg4_r <= sg_r;
      rg4_r <= rg3_r;

      for (int i = 0; i < 4; i++) sq_r[i] <= u_r[i] * u_r[i];
      cr_r[0] <= u_r[1] * u_r[2];
      cr_r[1] <= u_r[0] * u_r[3];
      cr_r[2] <= u_r[1] * u_r[3];
      cr_r[3] <= u_r[0] * u_r[2];
      cs_r    <= {sg4_r[0] ^ sg4_r[2], sg4_r[1] ^ sg4_r[3],
                  sg4_r[0] ^ sg4_r[3], sg4_r[1] ^ sg4_r[2]};
      rg5_r   <= rg4_r;

      den6_r <= DEN_W'(sq_r[0]) + DEN_W'(sq_r[1]) + DEN_W'(sq_r[2]) + DEN_W'(sq_r[3]);
      for (int i = 0; i < 3; i++) begin
        nm_r[i]  <= na[i][NMAG_W-1:0];
        ng6_r[i] <= nv[i][NS_W-1];
      end
      rg6_r <= rg5_r;

      for (int i = 0; i < 3; i++) begin
        plo_r[i] <= rg6_r * nm_r[i][NLO_W-1:0];
        phi_r[i] <= rg6_r * nm_r[i][NMAG_W-1:NLO_W];
      end
      den7_r <= den6_r;
      ng7_r  <= ng6_r;

      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (NUM_W'(phi_r[i]) << NLO_W) + NUM_W'(plo_r[i])
                  + NUM_W'(den7_r >> 1);
      end
      den8_r <= DDEN_W'(den7_r);
      ng8_r  <= ng7_r;
    end
  end

  assign num_o[0] = num_r[0];
  assign num_o[1] = num_r[1];
  assign num_o[2] = num_r[2];
  assign den_o    = den8_r;
  assign neg_o    = ng8_r;

endmodule
